// ===== hdl/mmrs_pkg.sv =====
// shared types and constants for the row-stream matrix multiplier
`default_nettype none

package mmrs_pkg;

   // default matrix size and field widths
   localparam int COLS_DEFAULT = 2;
   localparam int VALUE_W      = 32;
   localparam int SUM_W        = 64;

   // item function codes
   localparam logic FUNC_LOAD_B = 1'b0;
   localparam logic FUNC_ELEM_A = 1'b1;

   // control broadcast from the sequencer to every column cell
   typedef struct packed {
      logic a_go;       // an A element is taken this cycle
      logic s1_adv;     // product stage hands its beat to the accumulators
      logic s1_last;    // the product stage beat closes a row
      logic load_sums;  // final sums drop into the drain chain
      logic shift;      // drain chain moves one place toward the output
   } mmrs_ctl_type;

endpackage

`default_nettype wire

// ===== hdl/mmrs_cell.sv =====
// one column cell: B column store, multiply, accumulate and drain slot
`default_nettype none

module mmrs_cell #(
   parameter int COLS = 2,
   parameter int KW   = 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mmrs_pkg::mmrs_ctl_type      ctl,
   input  wire logic                        b_we,
   input  wire logic [KW-1:0]               b_widx,
   input  wire logic [mmrs_pkg::VALUE_W-1:0] value,
   input  wire logic [KW-1:0]               k,
   input  wire logic [mmrs_pkg::SUM_W-1:0]  slot_nbr,
   output logic [mmrs_pkg::SUM_W-1:0]       slot
);
   import mmrs_pkg::*;

   logic [VALUE_W-1:0] b_col_ff [COLS];
   logic [VALUE_W-1:0] b_rd;
   logic [SUM_W-1:0]   prod_ff;
   logic [SUM_W-1:0]   prod_in;
   logic [SUM_W-1:0]   acc_ff;
   logic [SUM_W-1:0]   sum_fin;
   logic [SUM_W-1:0]   slot_ff;

   // column of B, one entry per row
   always_ff @(posedge clock) begin
      if (b_we) begin
         b_col_ff[b_widx] <= value;
      end
   end

   // product of the A element with row k of this column
   assign b_rd    = b_col_ff[k];
   assign prod_in = {{(SUM_W-VALUE_W){1'b0}}, value} * {{(SUM_W-VALUE_W){1'b0}}, b_rd};

   always_ff @(posedge clock) begin
      if (ctl.a_go) begin
         prod_ff <= prod_in;
      end
   end

   // running column sum, cleared once a row closes
   assign sum_fin = acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctl.s1_adv) begin
         if (ctl.s1_last) begin
            acc_ff <= '0;
         end else begin
            acc_ff <= sum_fin;
         end
      end
   end

   // drain slot, fed from the neighbor cell while results go out
   always_ff @(posedge clock) begin
      if (ctl.load_sums) begin
         slot_ff <= sum_fin;
      end else if (ctl.shift) begin
         slot_ff <= slot_nbr;
      end
   end

   assign slot = slot_ff;

endmodule

`default_nettype wire

// ===== hdl/matrix_multiply_row_stream_top.sv =====
// top level of the row-stream matrix multiplier
//
// Multiplies rows of A by a COLS x COLS matrix B held in the block.
// Request beats: req_func selects a B load (b_row, b_col, value) or the next
// A element of the current row (value). Loads give no result.
// Response beats: after the last A element of a row, COLS sums go out in
// column order on rsp_sum with rsp_out_col, rsp_row_done marking the last.
// Each column is a cell holding its B column, a 32x32 multiplier with a
// product register, a 64-bit accumulator and a drain slot; the slots form
// a shift chain toward cell 0, which drives the response port.
// A row's last element fills the product registers, its sums enter the drain
// slots, then go out one per cycle. Throughput: one request beat per cycle;
// a row of COLS elements and its COLS sums keep pace with each other.
// Reset clears the accumulators, the row position and the drain count; B
// holds nothing defined until loaded. When the receiver stalls, the drain
// chain holds; once a finished row cannot enter the chain, req_ready drops.
`default_nettype none

module matrix_multiply_row_stream_top #(
   parameter int COLS = mmrs_pkg::COLS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_func,
   input  wire logic                         req_b_row,
   input  wire logic                         req_b_col,
   input  wire logic [mmrs_pkg::VALUE_W-1:0] req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_out_col,
   output logic [mmrs_pkg::SUM_W-1:0]        rsp_sum,
   output logic                              rsp_row_done
);
   import mmrs_pkg::*;

   localparam int KW = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int CW = $clog2(COLS + 1);

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_last_ff, s1_last_in;
   logic [KW-1:0] k_ff, k_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] out_idx;
   logic          take;
   logic          can_load;
   logic          s1_block;
   logic          req_go;
   logic          load_b;
   logic          row_ok;
   logic [KW-1:0] b_widx;
   mmrs_ctl_type  ctl;
   logic [SUM_W-1:0] slot_w [COLS+1];

   // handshake and pipeline control
   assign take      = rsp_valid && rsp_ready;
   assign can_load  = (cnt_ff == '0) || ((cnt_ff == CW'(1)) && take);
   assign s1_block  = s1_valid_ff && s1_last_ff && !can_load;
   assign req_ready = !s1_block;
   assign req_go    = req_valid && req_ready;
   assign load_b    = req_go && (req_func == FUNC_LOAD_B);
   assign row_ok    = (int'(req_b_row) < COLS);
   assign b_widx    = KW'(req_b_row);

   always_comb begin
      ctl.a_go      = req_go && (req_func == FUNC_ELEM_A);
      ctl.s1_adv    = s1_valid_ff && !s1_block;
      ctl.s1_last   = s1_last_ff;
      ctl.load_sums = s1_valid_ff && s1_last_ff && !s1_block;
      ctl.shift     = take;
   end

   // row position, product stage flags and drain count
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_last_in  = s1_last_ff;
      k_in        = k_ff;
      cnt_in      = cnt_ff;
      if (ctl.a_go) begin
         s1_valid_in = 1'b1;
         s1_last_in  = (k_ff == KW'(COLS - 1));
         k_in        = (k_ff == KW'(COLS - 1)) ? '0 : k_ff + KW'(1);
      end else if (ctl.s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (ctl.load_sums) begin
         cnt_in = CW'(COLS);
      end else if (take) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
         k_ff        <= '0;
         cnt_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_last_ff  <= s1_last_in;
         k_ff        <= k_in;
         cnt_ff      <= cnt_in;
      end
   end

   // chain of column cells, drained toward cell 0
   assign slot_w[COLS] = '0;

   for (genvar c = 0; c < COLS; c++) begin : g_cell
      logic b_we;
      assign b_we = load_b && row_ok && (int'(req_b_col) == c);

      mmrs_cell #(
         .COLS (COLS),
         .KW   (KW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .b_we     (b_we),
         .b_widx   (b_widx),
         .value    (req_value),
         .k        (k_ff),
         .slot_nbr (slot_w[c+1]),
         .slot     (slot_w[c])
      );
   end

   // response beat
   assign out_idx      = CW'(COLS) - cnt_ff;
   assign rsp_valid    = (cnt_ff != '0);
   assign rsp_sum      = slot_w[0];
   assign rsp_out_col  = out_idx[0];
   assign rsp_row_done = (cnt_ff == CW'(1));

endmodule

`default_nettype wire

// ===== tb/matrix_multiply_row_stream_top_test.sv =====
// self-checking testbench for the row-stream matrix multiplier
module matrix_multiply_row_stream_top_test;
   import mmrs_pkg::*;

   localparam int COLS        = COLS_DEFAULT;
   localparam int N_RANDOM    = 550;
   localparam int IDLE_PCT    = 12;
   localparam int HOLD_CYCLES = 300;
   localparam int N_DIRECTED  = 25;

   // one result beat as seen on the response port
   typedef struct packed {
      logic             out_col;
      logic [SUM_W-1:0] sum;
      logic             row_done;
   } sum_beat_type;

   // one request beat, with sums typed in where they are obvious
   typedef struct packed {
      logic               func;
      logic               b_row;
      logic               b_col;
      logic [VALUE_W-1:0] value;
      logic               typed;
      logic [SUM_W-1:0]   sum0;
      logic [SUM_W-1:0]   sum1;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_func;
   logic               req_b_row;
   logic               req_b_col;
   logic [VALUE_W-1:0] req_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_out_col;
   logic [SUM_W-1:0]   rsp_sum;
   logic               rsp_row_done;

   // predictor state
   logic [VALUE_W-1:0] b_copy [COLS*COLS];
   logic [SUM_W-1:0]   col_acc [COLS];
   int                 elem_pos;
   sum_beat_type       row_sums [COLS];

   sum_beat_type       pending_sums [$];
   int                 mismatches = 0;
   bit                 calm = 1'b0;
   bit                 hold_req = 1'b0;
   bit                 hold_taken;
   int                 hold_left;
   sum_beat_type       mon_want;
   sum_beat_type       mon_got;

   matrix_multiply_row_stream_top #(.COLS(COLS)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_b_row    (req_b_row),
      .req_b_col    (req_b_col),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_col  (rsp_out_col),
      .rsp_sum      (rsp_sum),
      .rsp_row_done (rsp_row_done)
   );

   always #5 clock = ~clock;

   // multiply-accumulate step for one accepted beat, returns number of sums
   function automatic int mac_predict(input logic func, input logic row, input logic col,
                                      input logic [VALUE_W-1:0] value);
      int k;
      if (func == FUNC_LOAD_B) begin
         if (int'(row) < COLS && int'(col) < COLS)
            b_copy[int'(row) * COLS + int'(col)] = value;
         return 0;
      end
      k = elem_pos;
      for (int c = 0; c < COLS; c++)
         col_acc[c] = col_acc[c] + SUM_W'(value) * SUM_W'(b_copy[k * COLS + c]);
      if (k + 1 < COLS) begin
         elem_pos = k + 1;
         return 0;
      end
      for (int c = 0; c < COLS; c++) begin
         row_sums[c].out_col  = c[0];
         row_sums[c].sum      = col_acc[c];
         row_sums[c].row_done = (c == COLS - 1);
         col_acc[c] = '0;
      end
      elem_pos = 0;
      return COLS;
   endfunction

   // element values leaning toward edges
   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return VALUE_W'($urandom_range(0, 15));
         3: return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
         4: return ~(VALUE_W'(1) << $urandom_range(0, VALUE_W - 1));
         default: return $urandom;
      endcase
   endfunction

   // offer one beat after a random gap, predict once it is taken
   task automatic drive_beat(input stim_row_type s);
      int           n;
      sum_beat_type typed_beat;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= s.func;
      req_b_row <= s.b_row;
      req_b_col <= s.b_col;
      req_value <= s.value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n = mac_predict(s.func, s.b_row, s.b_col, s.value);
      for (int c = 0; c < n; c++) begin
         if (s.typed) begin
            typed_beat.out_col  = c[0];
            typed_beat.sum      = (c == 0) ? s.sum0 : s.sum1;
            typed_beat.row_done = (c == COLS - 1);
            pending_sums.push_back(typed_beat);
         end else begin
            pending_sums.push_back(row_sums[c]);
         end
      end
      @(negedge clock);
   endtask

   // request side: reset, directed table, then random rows
   initial begin
      stim_row_type dir_tab [N_DIRECTED];
      stim_row_type s;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_func  = FUNC_LOAD_B;
      req_b_row = 1'b0;
      req_b_col = 1'b0;
      req_value = '0;
      for (int i = 0; i < COLS * COLS; i++) b_copy[i] = '0;
      for (int c = 0; c < COLS; c++) col_acc[c] = '0;
      elem_pos = 0;

      // zero matrix, then all-ones row of A
      dir_tab[0]  = '{FUNC_LOAD_B, 1'b0, 1'b0, 32'h0, 1'b0, 64'h0, 64'h0};
      dir_tab[1]  = '{FUNC_LOAD_B, 1'b0, 1'b1, 32'h0, 1'b0, 64'h0, 64'h0};
      dir_tab[2]  = '{FUNC_LOAD_B, 1'b1, 1'b0, 32'h0, 1'b0, 64'h0, 64'h0};
      dir_tab[3]  = '{FUNC_LOAD_B, 1'b1, 1'b1, 32'h0, 1'b0, 64'h0, 64'h0};
      dir_tab[4]  = '{FUNC_ELEM_A, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 64'h0, 64'h0};
      dir_tab[5]  = '{FUNC_ELEM_A, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1, 64'h0, 64'h0};
      // all-ones matrix: sums wrap past 2^64
      dir_tab[6]  = '{FUNC_LOAD_B, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 64'h0, 64'h0};
      dir_tab[7]  = '{FUNC_LOAD_B, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0, 64'h0, 64'h0};
      dir_tab[8]  = '{FUNC_LOAD_B, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, 64'h0, 64'h0};
      dir_tab[9]  = '{FUNC_LOAD_B, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 64'h0, 64'h0};
      dir_tab[10] = '{FUNC_ELEM_A, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0, 64'h0, 64'h0};
      dir_tab[11] = '{FUNC_ELEM_A, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1,
                      64'hFFFF_FFFC_0000_0002, 64'hFFFF_FFFC_0000_0002};
      dir_tab[12] = '{FUNC_ELEM_A, 1'b0, 1'b0, 32'h0, 1'b0, 64'h0, 64'h0};
      dir_tab[13] = '{FUNC_ELEM_A, 1'b0, 1'b0, 32'h0, 1'b1, 64'h0, 64'h0};
      // identity matrix passes the row through
      dir_tab[14] = '{FUNC_LOAD_B, 1'b0, 1'b0, 32'h1, 1'b0, 64'h0, 64'h0};
      dir_tab[15] = '{FUNC_LOAD_B, 1'b0, 1'b1, 32'h0, 1'b0, 64'h0, 64'h0};
      dir_tab[16] = '{FUNC_LOAD_B, 1'b1, 1'b0, 32'h0, 1'b0, 64'h0, 64'h0};
      dir_tab[17] = '{FUNC_LOAD_B, 1'b1, 1'b1, 32'h1, 1'b0, 64'h0, 64'h0};
      dir_tab[18] = '{FUNC_ELEM_A, 1'b0, 1'b0, 32'h1234_5678, 1'b0, 64'h0, 64'h0};
      dir_tab[19] = '{FUNC_ELEM_A, 1'b0, 1'b0, 32'h9ABC_DEF0, 1'b1,
                      64'h1234_5678, 64'h9ABC_DEF0};
      // load in the middle of a row, used by the rest of that row
      dir_tab[20] = '{FUNC_ELEM_A, 1'b0, 1'b0, 32'h5, 1'b0, 64'h0, 64'h0};
      dir_tab[21] = '{FUNC_LOAD_B, 1'b1, 1'b1, 32'h3, 1'b0, 64'h0, 64'h0};
      dir_tab[22] = '{FUNC_ELEM_A, 1'b0, 1'b0, 32'h7, 1'b0, 64'h0, 64'h0};
      // index fields set on elements are ignored
      dir_tab[23] = '{FUNC_ELEM_A, 1'b1, 1'b1, 32'hAAAA_AAAA, 1'b0, 64'h0, 64'h0};
      dir_tab[24] = '{FUNC_ELEM_A, 1'b1, 1'b0, 32'h5555_5555, 1'b0, 64'h0, 64'h0};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < N_DIRECTED; i++) drive_beat(dir_tab[i]);

      // random rows with occasional reloads of B, all entries already written
      for (int i = 0; i < N_RANDOM; i++) begin
         calm = (i >= 250 && i < 400);
         if (i == 100) hold_req = 1'b1;
         s.typed = 1'b0;
         s.sum0  = '0;
         s.sum1  = '0;
         s.func  = ($urandom_range(0, 99) < 80) ? FUNC_ELEM_A : FUNC_LOAD_B;
         s.b_row = 1'($urandom_range(0, 1));
         s.b_col = 1'($urandom_range(0, 1));
         s.value = rand_value();
         drive_beat(s);
      end
      req_valid <= 1'b0;

      // drain and let the pipeline settle
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_sums.size() == 0) begin
         $display("matrix_multiply_row_stream_top regression: pass");
      end else begin
         $display("matrix_multiply_row_stream_top regression: fail");
      end
      $finish;
   end

   // response side: random back-pressure plus one long hold-off
   initial begin
      rsp_ready  = 1'b0;
      hold_taken = 1'b0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // compare each result beat with the oldest expected sum
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         mon_got.out_col  = rsp_out_col;
         mon_got.sum      = rsp_sum;
         mon_got.row_done = rsp_row_done;
         if (pending_sums.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: col %0d sum %h done %0b",
                        mon_got.out_col, mon_got.sum, mon_got.row_done);
         end else begin
            mon_want = pending_sums.pop_front();
            if (mon_got !== mon_want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected col %0d sum %h done %0b, ",
                           mon_want.out_col, mon_want.sum, mon_want.row_done,
                           "got col %0d sum %h done %0b",
                           mon_got.out_col, mon_got.sum, mon_got.row_done);
            end
         end
      end
   end

   // watchdog
   initial begin
      #2000000;
      $display("matrix_multiply_row_stream_top regression: fail");
      $finish;
   end

endmodule
